// ----- rtl/assert_macros.svh -----
// Assertion helpers for checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/ebpf_pkg.sv -----
package ebpf_pkg;

    localparam logic [2:0] CLS_ALU   = 3'h4;
    localparam logic [2:0] CLS_ALU64 = 3'h7;
    localparam logic [7:0] OPC_LDDW  = 8'h18;
    localparam logic [7:0] SRC_BIT   = 8'h08;
    localparam logic [3:0] NUM_REGS  = 4'd10;

    localparam logic [3:0] OP_ADD  = 4'h0;
    localparam logic [3:0] OP_SUB  = 4'h1;
    localparam logic [3:0] OP_MUL  = 4'h2;
    localparam logic [3:0] OP_DIV  = 4'h3;
    localparam logic [3:0] OP_OR   = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LSH  = 4'h6;
    localparam logic [3:0] OP_RSH  = 4'h7;
    localparam logic [3:0] OP_NEG  = 4'h8;
    localparam logic [3:0] OP_MOD  = 4'h9;
    localparam logic [3:0] OP_XOR  = 4'ha;
    localparam logic [3:0] OP_MOV  = 4'hb;
    localparam logic [3:0] OP_ARSH = 4'hc;

    localparam logic [1:0] ST_WRITTEN = 2'd0;
    localparam logic [1:0] ST_BAD_DST = 2'd1;
    localparam logic [1:0] ST_UNSUPP  = 2'd2;

    // request to the shared multiply/divide unit
    typedef struct packed {
        logic        start;
        logic        is_mul;
        logic [63:0] a;
        logic [63:0] b;
    } md_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] prod;
        logic [63:0] quo;
        logic [63:0] rem;
    } md_rsp_t;

endpackage

// ----- rtl/ebpf_muldiv.sv -----
module ebpf_muldiv
    import ebpf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  md_req_t req,
    output md_rsp_t rsp
);

    logic [63:0] a_reg, b_reg, acc_reg, rem_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, mul_reg, done_reg;
    logic [65:0] trial;
    logic [64:0] rem_sh;

    // one shift-add or restoring-divide bit per cycle while busy
    assign rem_sh = {rem_reg, a_reg[63]};
    assign trial  = {1'b0, rem_sh} - {2'b0, b_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                mul_reg  <= req.is_mul;
                a_reg    <= req.a;
                b_reg    <= req.b;
                acc_reg  <= '0;
                rem_reg  <= '0;
                cnt_reg  <= 7'd64;
            end else if (busy_reg) begin
                if (mul_reg) begin
                    if (a_reg[0]) acc_reg <= acc_reg + b_reg;
                    a_reg <= {1'b0, a_reg[63:1]};
                    b_reg <= {b_reg[62:0], 1'b0};
                end else begin
                    a_reg <= {a_reg[62:0], 1'b0};
                    if (!trial[65]) begin
                        rem_reg <= trial[63:0];
                        acc_reg <= {acc_reg[62:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh[63:0];
                        acc_reg <= {acc_reg[62:0], 1'b0};
                    end
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
    assign rsp.quo  = acc_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- rtl/ebpf_alu_with_register_file.sv -----
// Channel | Dir | Fields (low bit up)
// s_*     | in  | tdata: opcode, dest_index, source_index, offset, immediate, immediate_high
// m_*     | out | tdata: result_value, written_index, status
// cfg_*   | in  | frame_pointer write
// Simple operations: registered on accept, executed in S_EXEC, result presented in S_OUT.
// Multiply and divide/modulo by a nonzero value: S_EXEC starts the 64 steps of the shared
// multiply/divide unit, S_WAIT waits for them, then the result is presented in S_OUT.
// Reset clears the register file, frame pointer and the state machine.
// s_tready is low from accept until the result transaction completes.
module ebpf_alu_with_register_file
    import ebpf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // opcode, dest_index, source_index, offset, imm, imm_high
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,   // result_value, written_index, status, zero pad
    input  logic         cfg_wr_en,
    input  logic [63:0]  cfg_wr_data
);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_WAIT, S_OUT} state_t;

    state_t      state_reg;
    logic [63:0] regs_reg [10];
    logic [63:0] fp_reg;
    logic [7:0]  opc_reg;
    logic [3:0]  dst_reg, srci_reg;
    logic [15:0] off_reg;
    logic [31:0] imm_reg, immh_reg;
    logic [63:0] res_reg;
    logic [3:0]  widx_reg;
    logic [1:0]  st_reg;
    logic        neg_q_reg, neg_r_reg, sgn_reg;

    md_req_t req;
    md_rsp_t rsp;

    ebpf_muldiv u_md (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    // operand decode
    logic        wide;
    logic [3:0]  op;
    logic [63:0] m, dv, sv, src_raw, imm64;
    logic [5:0]  sh;
    logic        sgn, unsupp, bad_dst, is_md, exe_cls;
    logic [63:0] sd, ss, res;

    assign wide  = opc_reg[2:0] == CLS_ALU64;
    assign op    = opc_reg[7:4];
    assign m     = wide ? '1 : 64'h0000_0000_ffff_ffff;
    assign imm64 = {{32{imm_reg[31]}}, imm_reg};
    assign src_raw = (opc_reg & SRC_BIT) != 8'h0 ?
                     (srci_reg < NUM_REGS ? regs_reg[srci_reg] : fp_reg) : imm64;
    assign dv    = (dst_reg < NUM_REGS ? regs_reg[dst_reg] : 64'h0) & m;
    assign sv    = src_raw & m;
    assign sh    = wide ? sv[5:0] : {1'b0, sv[4:0]};
    assign sd    = wide ? dv : {{32{dv[31]}}, dv[31:0]};
    assign ss    = wide ? sv : {{32{sv[31]}}, sv[31:0]};
    assign sgn   = off_reg != 16'h0;
    assign exe_cls = opc_reg[2:0] == CLS_ALU || wide || opc_reg == OPC_LDDW;
    assign bad_dst = dst_reg >= NUM_REGS;
    assign is_md = op == OP_MUL || ((op == OP_DIV || op == OP_MOD) && sv != 64'h0);

    always_comb begin
        unsupp = 1'b0;
        res    = '0;
        if (opc_reg == OPC_LDDW) begin
            res = {immh_reg, imm_reg};
        end else begin
            if ((opc_reg & SRC_BIT) != 8'h0 && srci_reg > NUM_REGS) unsupp = 1'b1;
            case (op)
                OP_ADD:  res = dv + sv;
                OP_SUB:  res = dv - sv;
                OP_OR:   res = dv | sv;
                OP_AND:  res = dv & sv;
                OP_LSH:  res = dv << sh;
                OP_RSH:  res = dv >> sh;
                OP_NEG:  res = 64'h0 - dv;
                OP_XOR:  res = dv ^ sv;
                OP_ARSH: res = $unsigned($signed(sd) >>> sh);
                OP_DIV:  res = '0;
                OP_MOD:  res = dv;
                OP_MUL:  res = '0;
                OP_MOV: begin
                    if (off_reg == 16'd0) res = sv;
                    else if (off_reg == 16'd8) res = {{56{sv[7]}}, sv[7:0]};
                    else if (off_reg == 16'd16) res = {{48{sv[15]}}, sv[15:0]};
                    else if (off_reg == 16'd32 && wide) res = {{32{sv[31]}}, sv[31:0]};
                    else unsupp = 1'b1;
                end
                default: unsupp = 1'b1;
            endcase
            res = res & m;
        end
    end

    // magnitudes for the unsigned divider
    logic [63:0] ma, mb, mdres, q_fix, r_fix;
    assign ma = sgn ? (sd[63] ? 64'h0 - sd : sd) : dv;
    assign mb = sgn ? (ss[63] ? 64'h0 - ss : ss) : sv;
    assign q_fix = neg_q_reg ? 64'h0 - rsp.quo : rsp.quo;
    assign r_fix = neg_r_reg ? 64'h0 - rsp.rem : rsp.rem;
    always_comb begin
        case (op)
            OP_MUL:  mdres = rsp.prod;
            OP_DIV:  mdres = sgn_reg ? q_fix : rsp.quo;
            default: mdres = sgn_reg ? r_fix : rsp.rem;
        endcase
        mdres = mdres & m;
    end

    assign req.start  = state_reg == S_EXEC && exe_cls && !bad_dst && !unsupp
                        && opc_reg != OPC_LDDW && is_md;
    assign req.is_mul = op == OP_MUL;
    assign req.a      = op == OP_MUL ? dv : ma;
    assign req.b      = op == OP_MUL ? sv : mb;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            fp_reg    <= '0;
            for (int i = 0; i < 10; i++) regs_reg[i] <= '0;
        end else begin
            if (cfg_wr_en) fp_reg <= cfg_wr_data;
            unique case (state_reg)
                S_IDLE: if (s_tvalid) begin
                    opc_reg  <= s_tdata[7:0];
                    dst_reg  <= s_tdata[11:8];
                    srci_reg <= s_tdata[15:12];
                    off_reg  <= s_tdata[31:16];
                    imm_reg  <= s_tdata[63:32];
                    immh_reg <= s_tdata[95:64];
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    res_reg  <= '0;
                    widx_reg <= '0;
                    if (!exe_cls) st_reg <= ST_UNSUPP;
                    else if (bad_dst) st_reg <= ST_BAD_DST;
                    else if (unsupp) st_reg <= ST_UNSUPP;
                    else st_reg <= ST_WRITTEN;
                    if (req.start) begin
                        sgn_reg   <= sgn;
                        neg_q_reg <= sd[63] ^ ss[63];
                        neg_r_reg <= sd[63];
                        state_reg <= S_WAIT;
                    end else begin
                        if (exe_cls && !bad_dst && !unsupp) begin
                            res_reg  <= res;
                            widx_reg <= dst_reg;
                            regs_reg[dst_reg] <= res;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_WAIT: if (rsp.done) begin
                    res_reg  <= mdres;
                    widx_reg <= dst_reg;
                    regs_reg[dst_reg] <= mdres;
                    state_reg <= S_OUT;
                end
                S_OUT: if (m_tready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = state_reg == S_OUT;
    assign m_tdata  = {2'b0, st_reg, widx_reg, res_reg};

endmodule

// ----- rtl/ebpf_checker.sv -----
`include "assert_macros.svh"
module ebpf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);
    `ASSERT_IMPL(a_excl, aclk, aresetn, m_tvalid, !s_tready, "ready while result pending")
    `ASSERT_IMPL(a_st, aclk, aresetn, m_tvalid, m_tdata[69:68] != 2'd3, "bad status")
    `ASSERT_IMPL(a_zero, aclk, aresetn, m_tvalid && m_tdata[69:68] != 2'd0,
        m_tdata[67:0] == 68'h0, "nonzero payload on failure")
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped")
    `ASSERT_NEXT(a_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready, "accepted twice")
endmodule

bind ebpf_alu_with_register_file ebpf_checker u_chk (.*);
